/* rtl/core/rffa_pkg.sv */
// ----------------------------------------------------------------------------
// rffa_pkg
// Shared types and constants for the first-fit rectangle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rffa_pkg;

    localparam int DIM_W  = 7;
    localparam int POS_W  = 6;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [DIM_W-1:0] ATLAS_DIM_RESET = 7'd64;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_ATLAS_WIDTH  = 2'd0;
    localparam reg_idx_t REG_ATLAS_HEIGHT = 2'd1;
    localparam reg_idx_t REG_LOCKED       = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/rectangle_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// rectangle_first_fit_allocator
// First-fit rectangle allocation over a row-wide occupancy bitmap memory.
// ----------------------------------------------------------------------------
// Locked, empty-atlas, zero-size and oversized requests skip the search and go
//   straight to the response. A search reads one bitmap row per cycle, column
//   by column, then marks the h rows it found with a read and a write each.
// Throughput: one request at a time; req_ready is high only while idle, and the
//   block returns to idle in the same cycle that it raises the response.
// Reset: rows read as free through per-row valid flags; atlas 64x64, unlocked.
`default_nettype none

module rectangle_first_fit_allocator #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rffa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rffa_pkg::DATA_W-1:0] pwdata,
    output logic      [rffa_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire rffa_pkg::req_t             req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output rffa_pkg::rsp_t                  rsp
);
    import rffa_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int DH = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

    // configuration
    logic [DIM_W-1:0] atlas_width_reg;
    logic [DIM_W-1:0] atlas_height_reg;
    logic             locked_reg;
    logic             cfg_wr;

    // bitmap memory
    logic [MAX_WIDTH-1:0]  occ_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] row_vld_reg;
    logic [MAX_WIDTH-1:0]  rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_en;
    logic [RW-1:0]         rd_addr;
    logic                  wr_en;
    logic [RW-1:0]         wr_addr;
    logic [MAX_WIDTH-1:0]  wr_data;
    logic [MAX_WIDTH-1:0]  row_eff;

    // sequencer
    state_t               state_reg, state_next;
    logic [CW-1:0]        x_reg, x_next;
    logic [DH-1:0]        scan_reg, scan_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [RW-1:0]        chk_row_reg, chk_row_next;
    logic [DH-1:0]        run_reg, run_next;
    logic [MAX_WIDTH-1:0] mask_reg, mask_next;
    logic [RW-1:0]        mark_row_reg, mark_row_next;
    logic [DH-1:0]        mark_cnt_reg, mark_cnt_next;
    logic [DW-1:0]        w_reg, w_next;
    logic [DH-1:0]        h_reg, h_next;
    logic [DW-1:0]        aw_reg, aw_next;
    logic [DH-1:0]        ah_reg, ah_next;
    rsp_t                 res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [MAX_WIDTH-1:0] base_mask;
    logic [DW-1:0]        aw_in;
    logic [DH-1:0]        ah_in;
    logic [DW-1:0]        w_in;
    logic [DH-1:0]        h_in;
    logic                 row_free;
    logic [DH-1:0]        run_inc;
    logic [DW:0]          x_end;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg  <= ATLAS_DIM_RESET;
            atlas_height_reg <= ATLAS_DIM_RESET;
            locked_reg       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ATLAS_WIDTH:  atlas_width_reg  <= pwdata[DIM_W-1:0];
                REG_ATLAS_HEIGHT: atlas_height_reg <= pwdata[DIM_W-1:0];
                REG_LOCKED:       locked_reg       <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_ATLAS_WIDTH:  prdata = DATA_W'(atlas_width_reg);
            REG_ATLAS_HEIGHT: prdata = DATA_W'(atlas_height_reg);
            REG_LOCKED:       prdata = DATA_W'(locked_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // bitmap memory, one row per word; unwritten rows read as free
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            occ_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= occ_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign row_eff = rd_vld_reg ? rd_data_reg : '0;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            base_mask[i] = (i < int'(req.rect_width));
        end
    end

    assign aw_in = (DW'(atlas_width_reg) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH)
                                                           : DW'(atlas_width_reg);
    assign ah_in = (DH'(atlas_height_reg) > DH'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT)
                                                             : DH'(atlas_height_reg);
    assign w_in  = DW'(req.rect_width);
    assign h_in  = DH'(req.rect_height);

    assign row_free = ((row_eff & mask_reg) == '0);
    assign run_inc  = run_reg + 1'b1;
    assign x_end    = (DW + 1)'(x_reg) + (DW + 1)'(w_reg) + 1'b1;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        scan_reg     <= scan_next;
        chk_row_reg  <= chk_row_next;
        run_reg      <= run_next;
        mask_reg     <= mask_next;
        mark_row_reg <= mark_row_next;
        mark_cnt_reg <= mark_cnt_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        aw_reg       <= aw_next;
        ah_reg       <= ah_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        scan_next      = scan_reg;
        chk_vld_next   = 1'b0;
        chk_row_next   = chk_row_reg;
        run_next       = run_reg;
        mask_next      = mask_reg;
        mark_row_next  = mark_row_reg;
        mark_cnt_next  = mark_cnt_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        aw_next        = aw_reg;
        ah_next        = ah_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = mark_row_reg;
        wr_data        = row_eff | mask_reg;
        req_ready      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    w_next    = w_in;
                    h_next    = h_in;
                    aw_next   = aw_in;
                    ah_next   = ah_in;
                    mask_next = base_mask;
                    x_next    = '0;
                    scan_next = '0;
                    run_next  = '0;
                    res_next  = '0;
                    if (locked_reg || aw_in == '0 || ah_in == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (w_in == '0 || h_in == '0)
                    begin
                        res_next.found = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else if (w_in > aw_in || h_in > ah_in)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next row read; its check happens in the next cycle
                if (scan_reg < ah_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = scan_reg[RW-1:0];
                    chk_vld_next = 1'b1;
                    chk_row_next = scan_reg[RW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    run_next = row_free ? run_inc : '0;
                    if (row_free && run_inc == h_reg)
                    begin
                        mark_row_next = RW'(DH'(chk_row_reg) + 1'b1 - h_reg);
                        mark_cnt_next = '0;
                        chk_vld_next  = 1'b0;
                        state_next    = ST_MARK_RD;
                    end
                    else if (DH'(chk_row_reg) + 1'b1 == ah_reg)
                    begin
                        // column exhausted
                        chk_vld_next = 1'b0;
                        scan_next    = '0;
                        run_next     = '0;
                        if (x_end > (DW + 1)'(aw_reg))
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            x_next    = x_reg + 1'b1;
                            mask_next = mask_reg << 1;
                        end
                    end
                end
            end

            ST_MARK_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = mark_row_reg;
                state_next = ST_MARK_WR;
            end

            ST_MARK_WR:
            begin
                wr_en         = 1'b1;
                mark_cnt_next = mark_cnt_reg + 1'b1;
                mark_row_next = mark_row_reg + 1'b1;
                if (mark_cnt_reg + 1'b1 == h_reg)
                begin
                    res_next.found = 1'b1;
                    res_next.pos_x = POS_W'(x_reg);
                    res_next.pos_y = POS_W'(RW'(DH'(mark_row_reg) + 1'b1 - h_reg));
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/rffa_checker.sv */
// ----------------------------------------------------------------------------
// rffa_checker
// Port-level checks for the first-fit rectangle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module rffa_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire rffa_pkg::rsp_t rsp
);
    import rffa_pkg::*;

    // one request in flight: ready drops straight after a transfer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("req_ready high right after a request transfer");

    // a response only appears after the block has been busy
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response raised without a preceding busy cycle");

    a_notfound_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.pos_x == '0 && rsp.pos_y == '0))
        else $error("not-found response with non-zero corner");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response dropped or changed");

endmodule

bind rectangle_first_fit_allocator rffa_checker u_rffa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

/* verif/tb_rectangle_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// tb_rectangle_first_fit_allocator
// Drives allocation requests and APB register writes into the allocator and
// checks every response against a behavioural occupancy bitmap kept in a
// small scoreboard. A directed pass covers zero-size, oversized, locked,
// empty and overlarge atlas cases; random phases then reconfigure the atlas
// and issue mostly small rectangles with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rectangle_first_fit_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import rffa_pkg::*;

    localparam int MAX_W       = 64;
    localparam int MAX_H       = 64;
    localparam int MAX_GAP     = 12;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 12;
    localparam int MAX_REPORTS = 10;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;

    bit quiet_tx;
    bit quiet_rx;

    class alloc_scoreboard;
        logic [MAX_W-1:0] occupancy [MAX_H];
        int unsigned      atlas_w;
        int unsigned      atlas_h;
        bit               locked;
        rsp_t             placements_q [$];
        int unsigned      mismatches;

        function new();
            foreach (occupancy[i])
                occupancy[i] = '0;
            atlas_w    = 32'(ATLAS_DIM_RESET);
            atlas_h    = 32'(ATLAS_DIM_RESET);
            locked     = 1'b0;
            mismatches = 0;
        endfunction

        function void configure(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ATLAS_WIDTH:  atlas_w = 32'(value[DIM_W-1:0]);
                REG_ATLAS_HEIGHT: atlas_h = 32'(value[DIM_W-1:0]);
                REG_LOCKED:       locked  = value[0];
                default:          ;
            endcase
        endfunction

        // first fit, column outer, row inner
        function void note_request(req_t r);
            int unsigned      w;
            int unsigned      h;
            int unsigned      aw;
            int unsigned      ah;
            int unsigned      x;
            int unsigned      y;
            int unsigned      row;
            logic [MAX_W-1:0] span;
            bit               free;
            bit               placed;
            rsp_t             e;

            w      = 32'(r.rect_width);
            h      = 32'(r.rect_height);
            aw     = (atlas_w > MAX_W) ? MAX_W : atlas_w;
            ah     = (atlas_h > MAX_H) ? MAX_H : atlas_h;
            e      = '0;
            placed = 1'b0;

            if (!locked && aw != 0 && ah != 0) begin
                if (w == 0 || h == 0)
                    e.found = 1'b1;
                else if (w <= aw && h <= ah) begin
                    for (x = 0; x + w <= aw && !placed; x++) begin
                        span = ({MAX_W{1'b1}} >> (MAX_W - w)) << x;
                        for (y = 0; y + h <= ah && !placed; y++) begin
                            free = 1'b1;
                            for (row = y; row < y + h; row++)
                                if ((occupancy[row] & span) != '0)
                                    free = 1'b0;
                            if (free) begin
                                for (row = y; row < y + h; row++)
                                    occupancy[row] |= span;
                                placed  = 1'b1;
                                e.found = 1'b1;
                                e.pos_x = x[POS_W-1:0];
                                e.pos_y = y[POS_W-1:0];
                            end
                        end
                    end
                end
            end
            placements_q.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;

            if (placements_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: unrequested response found=%0d pos=(%0d,%0d)",
                             $realtime, got.found, got.pos_x, got.pos_y);
            end
            else begin
                e = placements_q.pop_front();
                if (got.found !== e.found || got.pos_x !== e.pos_x ||
                    got.pos_y !== e.pos_y) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%t: response mismatch exp found=%0d pos=(%0d,%0d)",
                                  " got found=%0d pos=(%0d,%0d)"},
                                 $realtime, e.found, e.pos_x, e.pos_y,
                                 got.found, got.pos_x, got.pos_y);
                end
            end
        endfunction

        function int unsigned pending();
            return placements_q.size();
        endfunction
    endclass

    alloc_scoreboard sb = new();

    rectangle_first_fit_allocator #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    // response side: random stall per transfer
    initial
    begin
        int unsigned stall;

        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.configure(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits are don't-care
    task automatic set_atlas(int unsigned w, int unsigned h, bit lock);
        write_reg(REG_ATLAS_WIDTH,
                  DATA_W'({$urandom_range(0, 1) ? $urandom : 32'd0, 7'd0} | w));
        write_reg(REG_ATLAS_HEIGHT, h);
        write_reg(REG_LOCKED,       DATA_W'({$urandom, 1'b0} | lock));
    endtask

    task automatic request_rect(int unsigned w, int unsigned h);
        int unsigned gap;
        req_t        r;

        r.rect_width  = w[DIM_W-1:0];
        r.rect_height = h[DIM_W-1:0];
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned pick_dim();
        int unsigned sel;

        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return $urandom_range(65, 127);
        if (sel == 2)
            return 64;
        return $urandom_range(1, 64);
    endfunction

    function automatic int unsigned pick_side();
        int unsigned sel;

        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return $urandom_range(65, 127);
        if (sel == 2)
            return $urandom_range(1, 64);
        return $urandom_range(1, 8);
    endfunction

    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        quiet_tx  = 1'b0;
        quiet_rx  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset atlas, 64 x 64
        request_rect(0, 0);
        request_rect(127, 0);
        request_rect(0, 64);
        request_rect(1, 1);
        request_rect(65, 1);
        request_rect(1, 65);
        request_rect(127, 127);
        request_rect(64, 1);
        request_rect(1, 64);
        request_rect(3, 2);
        drain();

        set_atlas(64, 64, 1'b1);
        request_rect(1, 1);
        request_rect(0, 0);
        drain();

        set_atlas(0, 64, 1'b0);
        request_rect(0, 0);
        request_rect(2, 2);
        drain();

        set_atlas(64, 0, 1'b0);
        request_rect(1, 1);
        drain();

        set_atlas(1, 1, 1'b0);
        request_rect(1, 1);
        request_rect(2, 1);
        drain();

        // beyond the parameter limits, acts as 64 x 64
        set_atlas(127, 100, 1'b0);
        request_rect(5, 7);
        request_rect(64, 64);
        request_rect(2, 2);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            set_atlas(pick_dim(), pick_dim(), $urandom_range(0, 7) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                request_rect(pick_side(), pick_side());
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/rffa_pkg.sv
rtl/core/rectangle_first_fit_allocator.sv
rtl/core/rffa_checker.sv
verif/tb_rectangle_first_fit_allocator.sv
